// File: rtl/core/ipv4_header_checker_assert.svh
// Assertion macros used by the IPv4 header checker RTL.
`ifndef IPV4_HEADER_CHECKER_ASSERT_SVH
`define IPV4_HEADER_CHECKER_ASSERT_SVH

`ifndef ASSERT_OFF

// Combinational condition that must hold at every clock edge out of reset.
`define IHC_ASSERT_ALWAYS(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("assertion failed");

// Same-cycle implication.
`define IHC_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

`else

`define IHC_ASSERT_ALWAYS(lbl, clk, rst_n, cond)
`define IHC_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons)

`endif

`endif

// File: rtl/core/ihc_pkg.sv
// Types and constants for the IPv4 header checker.
package ihc_pkg;

    typedef enum logic [2:0] {
        ST_OK      = 3'd0,
        ST_VERSION = 3'd1,
        ST_SHORT   = 3'd2,
        ST_TTL     = 3'd3,
        ST_CSUM    = 3'd4,
        ST_TRUNC   = 3'd5
    } t_status;

    typedef enum logic [1:0] {
        PC_ICMP  = 2'd0,
        PC_UDP   = 2'd1,
        PC_OTHER = 2'd2
    } t_proto_class;

    localparam logic [3:0]  IP_VERSION  = 4'd4;
    localparam logic [3:0]  MIN_IHL     = 4'd5;
    localparam logic [7:0]  PROTO_ICMP  = 8'd1;
    localparam logic [7:0]  PROTO_UDP   = 8'd17;
    localparam logic [15:0] CSUM_GOOD   = 16'hFFFF;

    // Header byte offsets
    localparam logic [5:0] OFS_LEN_HI  = 6'd2;
    localparam logic [5:0] OFS_LEN_LO  = 6'd3;
    localparam logic [5:0] OFS_ID_HI   = 6'd4;
    localparam logic [5:0] OFS_ID_LO   = 6'd5;
    localparam logic [5:0] OFS_TTL     = 6'd8;
    localparam logic [5:0] OFS_PROTO   = 6'd9;
    localparam logic [5:0] OFS_SRC_LO  = 6'd12;
    localparam logic [5:0] OFS_SRC_HI  = 6'd15;
    localparam logic [5:0] OFS_DST_LO  = 6'd16;
    localparam logic [5:0] OFS_DST_HI  = 6'd19;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last;
    } t_in_item;

    typedef struct packed {
        t_status      status;
        t_proto_class proto_class;
        logic [7:0]   proto_number;
        logic [31:0]  source_addr;
        logic [31:0]  dest_addr;
        logic [15:0]  ident;
        logic [15:0]  body_length;
    } t_out_item;

endpackage

// File: rtl/core/ipv4_header_checker.sv
// Top level of the IPv4 header checker: byte-serial header parse and verdict.
//
// Takes an IPv4 packet one byte per transfer (with a last mark on the final
// byte) and gives one verdict per packet: on the first byte when the version
// is not 4 or IHL is below 5, on the byte that completes IHL*4 header bytes
// otherwise (TTL zero, then checksum), or truncated when the packet ends
// first. Bytes after the verdict are dropped up to last. Throughput is one
// byte per cycle while the result register is not stalled; a byte is held
// in the input register, then the header logic updates state and loads the
// result register from it, whose outputs hold the verdict until it transfers.
// When the result register is stalled the input register still takes one
// byte, then the input stalls until the result transfers.
`include "ipv4_header_checker_assert.svh"

module ipv4_header_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  ihc_pkg::t_in_item  i_in,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output ihc_pkg::t_out_item o_out
);
    import ihc_pkg::*;

    // input register
    logic       r_in_valid;
    t_in_item   r_in;

    // parse state
    logic [5:0]  r_bc;
    logic [3:0]  r_hw;
    logic [3:0]  r_ver;
    logic [15:0] r_sum;
    logic [7:0]  r_high;
    logic [15:0] r_tlen;
    logic [15:0] r_ident;
    logic [7:0]  r_ttl;
    logic [7:0]  r_proto;
    logic [31:0] r_src;
    logic [31:0] r_dst;
    logic        r_verdict;

    // result register
    logic       r_out_valid;
    t_out_item  r_out;

    logic        out_free;
    logic        fire;
    logic        first;
    logic [7:0]  b;
    logic [5:0]  n_bc;
    logic [3:0]  n_hw;
    logic [3:0]  n_ver;
    logic [15:0] n_sum;
    logic [16:0] sum_raw;
    logic [7:0]  n_high;
    logic [15:0] n_tlen;
    logic [15:0] n_ident;
    logic [7:0]  n_ttl;
    logic [7:0]  n_proto;
    logic [31:0] n_src;
    logic [31:0] n_dst;
    logic        emit;
    t_status     n_status;
    logic [15:0] hdr_bytes;
    t_out_item   n_out;

    assign out_free   = !r_out_valid || !i_out_stall;
    assign fire       = r_in_valid && out_free;
    assign o_in_stall = r_in_valid && !out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
        if (!o_in_stall && i_in_valid) begin
            r_in <= i_in;
        end
    end

    // Next-state and verdict for the byte in the input register.
    always_comb begin
        b     = r_in.data_byte;
        first = (r_bc == '0);

        // a new packet starts from cleared holds
        n_hw    = first ? b[3:0] : r_hw;
        n_ver   = first ? b[7:4] : r_ver;
        n_sum   = first ? '0 : r_sum;
        n_high  = first ? '0 : r_high;
        n_tlen  = first ? '0 : r_tlen;
        n_ident = first ? '0 : r_ident;
        n_ttl   = first ? '0 : r_ttl;
        n_proto = first ? '0 : r_proto;
        n_src   = first ? '0 : r_src;
        n_dst   = first ? '0 : r_dst;

        // odd offset closes a 16-bit word: end-around carry add
        sum_raw = {1'b0, n_sum} + {1'b0, n_high, b};
        if (r_bc[0]) begin
            n_sum = sum_raw[15:0] + {15'd0, sum_raw[16]};
        end else begin
            n_high = b;
        end

        if (r_bc == OFS_LEN_HI || r_bc == OFS_LEN_LO) begin
            n_tlen = {n_tlen[7:0], b};
        end else if (r_bc == OFS_ID_HI || r_bc == OFS_ID_LO) begin
            n_ident = {n_ident[7:0], b};
        end else if (r_bc == OFS_TTL) begin
            n_ttl = b;
        end else if (r_bc == OFS_PROTO) begin
            n_proto = b;
        end else if (r_bc >= OFS_SRC_LO && r_bc <= OFS_SRC_HI) begin
            n_src = {n_src[23:0], b};
        end else if (r_bc >= OFS_DST_LO && r_bc <= OFS_DST_HI) begin
            n_dst = {n_dst[23:0], b};
        end

        n_bc = r_bc + 6'd1;

        emit     = 1'b1;
        n_status = ST_OK;
        if (first && (n_ver != IP_VERSION || n_hw < MIN_IHL)) begin
            n_status = (n_ver != IP_VERSION) ? ST_VERSION : ST_SHORT;
        end else if (n_hw >= MIN_IHL && n_bc == {n_hw, 2'b00}) begin
            if (n_ttl == '0) begin
                n_status = ST_TTL;
            end else if (n_sum != CSUM_GOOD) begin
                n_status = ST_CSUM;
            end else begin
                n_status = ST_OK;
            end
        end else if (r_in.last) begin
            n_status = ST_TRUNC;
        end else begin
            emit = 1'b0;
        end
        if (r_verdict) begin
            emit = 1'b0;
        end

        hdr_bytes          = {10'd0, n_hw, 2'b00};
        n_out.status       = n_status;
        n_out.proto_class  = (n_proto == PROTO_ICMP) ? PC_ICMP :
                             (n_proto == PROTO_UDP)  ? PC_UDP  : PC_OTHER;
        n_out.proto_number = n_proto;
        n_out.source_addr  = n_src;
        n_out.dest_addr    = n_dst;
        n_out.ident        = n_ident;
        n_out.body_length  = (n_tlen > hdr_bytes) ? (n_tlen - hdr_bytes) : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bc      <= '0;
            r_hw      <= '0;
            r_ver     <= '0;
            r_sum     <= '0;
            r_high    <= '0;
            r_tlen    <= '0;
            r_ident   <= '0;
            r_ttl     <= '0;
            r_proto   <= '0;
            r_src     <= '0;
            r_dst     <= '0;
            r_verdict <= 1'b0;
        end else if (fire) begin
            if (!r_verdict) begin
                r_hw    <= n_hw;
                r_ver   <= n_ver;
                r_sum   <= n_sum;
                r_high  <= n_high;
                r_tlen  <= n_tlen;
                r_ident <= n_ident;
                r_ttl   <= n_ttl;
                r_proto <= n_proto;
                r_src   <= n_src;
                r_dst   <= n_dst;
            end
            // last always closes the packet
            if (r_in.last) begin
                r_bc      <= '0;
                r_verdict <= 1'b0;
            end else if (!r_verdict) begin
                r_bc      <= n_bc;
                r_verdict <= emit;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire && emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
        if (fire && emit) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // mid-header: count never reaches the header end without a verdict
    `IHC_ASSERT_IMPLY(a_bc_in_header, i_clk, i_rst_n, !r_verdict && r_bc != '0, r_hw >= MIN_IHL && r_bc < {r_hw, 2'b00})
    // after a verdict at least one byte of the packet was counted
    `IHC_ASSERT_IMPLY(a_verdict_bc, i_clk, i_rst_n, r_verdict, r_bc != '0)
    // input stalls only with a byte held
    `IHC_ASSERT_IMPLY(a_stall_held, i_clk, i_rst_n, o_in_stall, r_in_valid && r_out_valid)
    // ICMP class agrees with the raw protocol byte
    `IHC_ASSERT_IMPLY(a_class_match, i_clk, i_rst_n, r_out_valid, (r_out.proto_class == PC_ICMP) == (r_out.proto_number == PROTO_ICMP))

endmodule

// File: verif/tb_ipv4_header_checker.sv
// Self-checking testbench for the byte-serial IPv4 header checker.
module tb_ipv4_header_checker;
    import ihc_pkg::*;

    localparam int BYTES_PER_PHASE = 650;
    localparam int QUIET_LIMIT     = 2000;  // cycles with no transfer while work is pending
    localparam int DRAIN_CYCLES    = 8;     // settle time before the final check

    typedef enum {
        PK_GOOD, PK_BADSUM, PK_TTL0, PK_TRUNC, PK_BADVER, PK_SHORT, PK_NOISE
    } t_pkt_kind;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_in_valid = 1'b0;
    logic      o_in_stall;
    t_in_item  i_in = '0;
    logic      o_out_valid;
    logic      i_out_stall = 1'b0;
    t_out_item o_out;

    ipv4_header_checker dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out)
    );

    // Stimulus bytes waiting for the driver, and verdicts still owed by the block.
    t_in_item  byte_q[$];
    t_out_item verdict_q[$];

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int bytes_queued   = 0;
    int bytes_taken    = 0;
    int verdicts_seen  = 0;
    int err_cnt        = 0;
    int quiet_cycles   = 0;
    int status_tally[0:5];
    bit in_took        = 1'b0;  // input transfer at the last rising edge

    // Header parse state of the predictor.
    logic [5:0]  hdr_pos      = '0;
    logic [3:0]  ihl_q        = '0;
    logic [3:0]  ver_q        = '0;
    logic [16:0] csum_acc     = '0;
    logic [7:0]  hi_byte      = '0;
    logic [15:0] tot_len      = '0;
    logic [15:0] id_q         = '0;
    logic [7:0]  ttl_q        = '0;
    logic [7:0]  prot_q       = '0;
    logic [31:0] src_q        = '0;
    logic [31:0] dst_q        = '0;
    bit          verdict_done = 1'b0;

    // Feeds one byte into the parse state; returns 1 when it yields a verdict.
    function automatic bit parse_header_byte(input t_in_item it, output t_out_item res);
        logic [5:0] idx;
        logic [7:0] b;
        bit         fire;
        t_status    st;
        int         hdr_bytes;
        b    = it.data_byte;
        fire = 1'b0;
        st   = ST_OK;
        res  = '0;
        if (!verdict_done) begin
            idx = hdr_pos;
            // First byte of a packet: drop everything held from the previous one.
            if (idx == 6'd0) begin
                ihl_q    = b[3:0];
                ver_q    = b[7:4];
                csum_acc = '0;
                hi_byte  = '0;
                tot_len  = '0;
                id_q     = '0;
                ttl_q    = '0;
                prot_q   = '0;
                src_q    = '0;
                dst_q    = '0;
            end
            // Ones'-complement sum over big-endian words, carry folded back each word.
            if (idx[0]) begin
                csum_acc = csum_acc + {hi_byte, b};
                csum_acc = {1'b0, csum_acc[15:0]} + csum_acc[16];
            end else begin
                hi_byte = b;
            end
            if (idx == OFS_LEN_HI || idx == OFS_LEN_LO)
                tot_len = {tot_len[7:0], b};
            else if (idx == OFS_ID_HI || idx == OFS_ID_LO)
                id_q = {id_q[7:0], b};
            else if (idx == OFS_TTL)
                ttl_q = b;
            else if (idx == OFS_PROTO)
                prot_q = b;
            else if (idx >= OFS_SRC_LO && idx <= OFS_SRC_HI)
                src_q = {src_q[23:0], b};
            else if (idx >= OFS_DST_LO && idx <= OFS_DST_HI)
                dst_q = {dst_q[23:0], b};
            hdr_pos   = idx + 6'd1;
            hdr_bytes = int'(ihl_q) * 4;

            // Version and IHL are decided on the first byte; the rest when the header closes.
            if (idx == 6'd0 && (ver_q != IP_VERSION || ihl_q < MIN_IHL)) begin
                fire = 1'b1;
                st   = (ver_q != IP_VERSION) ? ST_VERSION : ST_SHORT;
            end else if (ihl_q >= MIN_IHL && int'(hdr_pos) == hdr_bytes) begin
                fire = 1'b1;
                if (ttl_q == 8'd0)
                    st = ST_TTL;
                else if (csum_acc != {1'b0, CSUM_GOOD})
                    st = ST_CSUM;
                else
                    st = ST_OK;
            end else if (it.last) begin
                fire = 1'b1;
                st   = ST_TRUNC;
            end

            if (fire) begin
                res.status       = st;
                res.proto_class  = (prot_q == PROTO_ICMP) ? PC_ICMP :
                                   (prot_q == PROTO_UDP)  ? PC_UDP  : PC_OTHER;
                res.proto_number = prot_q;
                res.source_addr  = src_q;
                res.dest_addr    = dst_q;
                res.ident        = id_q;
                res.body_length  = (int'(tot_len) > hdr_bytes) ?
                                   16'(int'(tot_len) - hdr_bytes) : 16'd0;
                verdict_done     = 1'b1;
            end
        end
        // The last byte always closes the packet, verdict or not.
        if (it.last) begin
            hdr_pos      = '0;
            verdict_done = 1'b0;
        end
        return fire;
    endfunction

    task automatic check_verdict(input t_out_item got);
        t_out_item want;
        verdicts_seen++;
        if (verdict_q.size() == 0) begin
            $display("%0t: verdict with none pending, got status %0d", $time, got.status);
            err_cnt++;
        end else begin
            want = verdict_q.pop_front();
            if (got.status !== want.status) begin
                $display("%0t: status exp %0d got %0d", $time, want.status, got.status);
                err_cnt++;
            end
            if (got.proto_class !== want.proto_class) begin
                $display("%0t: proto_class exp %0d got %0d", $time,
                         want.proto_class, got.proto_class);
                err_cnt++;
            end
            if (got.proto_number !== want.proto_number) begin
                $display("%0t: proto_number exp %0d got %0d", $time,
                         want.proto_number, got.proto_number);
                err_cnt++;
            end
            if (got.source_addr !== want.source_addr) begin
                $display("%0t: source_addr exp %h got %h", $time,
                         want.source_addr, got.source_addr);
                err_cnt++;
            end
            if (got.dest_addr !== want.dest_addr) begin
                $display("%0t: dest_addr exp %h got %h", $time,
                         want.dest_addr, got.dest_addr);
                err_cnt++;
            end
            if (got.ident !== want.ident) begin
                $display("%0t: ident exp %h got %h", $time, want.ident, got.ident);
                err_cnt++;
            end
            if (got.body_length !== want.body_length) begin
                $display("%0t: body_length exp %0d got %0d", $time,
                         want.body_length, got.body_length);
                err_cnt++;
            end
        end
    endtask

    task automatic queue_byte(input logic [7:0] b, input logic is_last);
        t_in_item it;
        it.data_byte = b;
        it.last      = is_last;
        byte_q.push_back(it);
        bytes_queued++;
    endtask

    // Builds one packet of the given kind. Well-formed headers carry a correct
    // checksum; the bad-checksum, TTL-zero and truncated kinds damage exactly one thing.
    task automatic queue_packet(input t_pkt_kind kind, input int ihl, input int tail);
        logic [7:0]  hb [0:59];
        logic [16:0] acc;
        logic [3:0]  ver;
        int          hlen, n, pick;
        hlen = ihl * 4;
        for (int k = 0; k < 60; k++) hb[k] = 8'($urandom);
        if (kind == PK_NOISE) begin
            // Half the noise starts with version 4 so it can get past the first byte.
            if ($urandom_range(1) == 0) hb[0] = {IP_VERSION, 4'($urandom)};
            n = $urandom_range(1, 24);
            for (int k = 0; k < n; k++)
                queue_byte(hb[k], (k == n - 1) || ($urandom_range(7) == 0));
        end else if (kind == PK_BADVER || kind == PK_SHORT) begin
            ver   = (kind == PK_SHORT) ? IP_VERSION : 4'(IP_VERSION + $urandom_range(1, 15));
            hb[0] = {ver, (kind == PK_SHORT) ? 4'($urandom_range(0, 4)) : hb[0][3:0]};
            n     = $urandom_range(1, 6);
            for (int k = 0; k < n; k++) queue_byte(hb[k], k == n - 1);
        end else begin
            hb[0] = {IP_VERSION, 4'(ihl)};
            // total length mostly matches, sometimes arbitrary (short or huge)
            pick = $urandom_range(3);
            {hb[2], hb[3]} = (pick == 0) ? 16'($urandom) : 16'(hlen + tail);
            pick = $urandom_range(2);
            if (pick == 0)      hb[9] = PROTO_ICMP;
            else if (pick == 1) hb[9] = PROTO_UDP;
            if (kind == PK_TTL0)     hb[8] = 8'd0;
            else if (hb[8] == 8'd0)  hb[8] = 8'd1;
            hb[10] = 8'd0;
            hb[11] = 8'd0;
            acc = '0;
            for (int k = 0; k < hlen; k += 2) begin
                acc = acc + {hb[k], hb[k + 1]};
                acc = {1'b0, acc[15:0]} + acc[16];
            end
            {hb[10], hb[11]} = ~acc[15:0];
            if (kind == PK_BADSUM) hb[10] = hb[10] ^ 8'($urandom_range(1, 255));
            n = (kind == PK_TRUNC) ? $urandom_range(1, hlen - 1) : hlen + tail;
            for (int k = 0; k < n; k++)
                queue_byte((k < hlen) ? hb[k] : 8'($urandom), k == n - 1);
        end
    endtask

    task automatic queue_random_packet();
        t_pkt_kind kind;
        int        r, ihl, tail;
        r    = $urandom_range(99);
        ihl  = ($urandom_range(3) == 0) ? $urandom_range(6, 15) : 5;
        tail = ($urandom_range(9) == 0) ? $urandom_range(9, 40) : $urandom_range(0, 8);
        if (r < 40)      kind = PK_GOOD;
        else if (r < 52) kind = PK_BADSUM;
        else if (r < 60) kind = PK_TTL0;
        else if (r < 72) kind = PK_TRUNC;
        else if (r < 80) kind = PK_BADVER;
        else if (r < 86) kind = PK_SHORT;
        else             kind = PK_NOISE;
        queue_packet(kind, ihl, tail);
    endtask

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // Driver: a byte stays on the bus until it transfers; new bytes and the
    // output stall change on the falling edge only.
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (!i_in_valid || in_took) begin
                if (byte_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                    i_in       <= byte_q.pop_front();
                    i_in_valid <= 1'b1;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
            i_out_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    // Monitor: predicts on every input transfer, checks every output transfer.
    always @(posedge i_clk) begin
        t_out_item pred;
        bit        out_took;
        in_took  = 1'b0;
        out_took = 1'b0;
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall) begin
                in_took = 1'b1;
                bytes_taken++;
                if (parse_header_byte(i_in, pred)) begin
                    verdict_q.push_back(pred);
                    status_tally[int'(pred.status)]++;
                end
            end
            if (o_out_valid && !i_out_stall) begin
                out_took = 1'b1;
                check_verdict(o_out);
            end
            // Watchdog only runs while something is still owed.
            if (in_took || out_took ||
                (byte_q.size() == 0 && !i_in_valid && verdict_q.size() == 0)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
                if (quiet_cycles >= QUIET_LIMIT) begin
                    $display("%0t: no transfer for %0d cycles", $time, QUIET_LIMIT);
                    $display("RESULT: ERROR");
                    $finish;
                end
            end
        end
    end

    initial begin
        for (int s = 0; s < 6; s++) status_tally[s] = 0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (int phase = 0; phase < 3; phase++) begin
            // sender-light/receiver-heavy, then reversed, then full rate
            send_idle_pct  = (phase == 0) ? 11 : (phase == 1) ? 85 : 0;
            recv_stall_pct = (phase == 0) ? 85 : (phase == 1) ? 11 : 0;
            if (phase == 0) begin
                queue_packet(PK_GOOD, 5, 0);   // header closes exactly on last
                queue_byte(8'hF5, 1'b1);       // version 15
                queue_byte(8'h00, 1'b1);       // version 0, IHL 0
                queue_byte(8'h40, 1'b1);       // IHL 0 with good version
                queue_byte(8'h4F, 1'b1);       // IHL 15, ends after one byte
            end
            while (bytes_queued < BYTES_PER_PHASE * (phase + 1)) queue_random_packet();
            // Hold the next phase back until every owed verdict has come out.
            while (byte_q.size() != 0 || i_in_valid || verdict_q.size() != 0)
                @(posedge i_clk);
        end

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (verdict_q.size() != 0) begin
            $display("%0t: %0d verdicts never arrived", $time, verdict_q.size());
            err_cnt++;
        end
        $display("Run covered %0d bytes in, %0d verdicts out, %0d mismatches.",
                 bytes_taken, verdicts_seen, err_cnt);
        $display("Verdicts: ok %0d, version %0d, short %0d, ttl %0d, csum %0d, trunc %0d.",
                 status_tally[0], status_tally[1], status_tally[2],
                 status_tally[3], status_tally[4], status_tally[5]);
        if (err_cnt == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// File: sim.f
+incdir+rtl/core
rtl/core/ihc_pkg.sv
rtl/core/ipv4_header_checker.sv
verif/tb_ipv4_header_checker.sv
